// ===== hdl/reed_pkg.sv =====
// Shared types and constants for the RSSI energy event detector.
package reed_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_NOISE  = 2'd1,
    ACT_DETECT = 2'd2
  } reed_action_e;

  typedef enum logic [1:0] {
    CLOSE_NONE   = 2'd0,
    CLOSE_ACCEPT = 2'd1,
    CLOSE_SHORT  = 2'd2
  } reed_closed_e;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } reed_state_e;

  localparam logic [1:0] REG_MARGIN     = 2'd0;
  localparam logic [1:0] REG_HYSTERESIS = 2'd1;
  localparam logic [1:0] REG_MIN_EVENT  = 2'd2;

  localparam logic [6:0]  MARGIN_RESET     = 7'd20;
  localparam logic [6:0]  HYSTERESIS_RESET = 7'd6;
  localparam logic [15:0] MIN_EVENT_RESET  = 16'd10;

  localparam logic signed [11:0] PEAK_NONE = -12'sd1998;

  typedef struct packed {
    logic exec;
    logic use_held;
    logic capture;
    logic div_start;
  } reed_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
  } reed_sts_t;

endpackage

// ===== hdl/reed_ctrl.sv =====
// Controller state machine: request handshakes and divider sequencing.
module reed_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  reed_pkg::reed_sts_t sts_i,
  output reed_pkg::reed_cmd_t cmd_o
);
  import reed_pkg::*;

  reed_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        accept;

  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.need_div) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done && slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = slot_free;
        cmd_o.capture   = accept && sts_i.need_div;
        cmd_o.div_start = accept && sts_i.need_div;
        cmd_o.exec      = accept && !sts_i.need_div;
      end
      ST_DIV: begin
        cmd_o.use_held = 1'b1;
        cmd_o.exec     = sts_i.div_done && slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.exec || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/reed_dp.sv =====
// Datapath: configuration, run state, noise floor divider and result registers.
module reed_dp #(
  parameter int NOISE_SAMPLES_MAX = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          action_i,
  input  logic signed [9:0]   rssi_i,
  input  logic [31:0]         time_ms_i,
  input  reed_pkg::reed_cmd_t cmd_i,
  output reed_pkg::reed_sts_t sts_o,
  output logic                in_event_o,
  output logic [1:0]          event_closed_o,
  output logic [31:0]         event_duration_ms_o,
  output logic [15:0]         event_count_o,
  output logic [15:0]         short_count_o,
  output logic [31:0]         airtime_ms_o,
  output logic signed [11:0]  best_peak_o,
  output logic signed [9:0]   noise_floor_o
);
  import reed_pkg::*;

  localparam int CNT_W  = $clog2(NOISE_SAMPLES_MAX + 1);
  localparam int SUM_W  = 10 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic [6:0]  margin_q, margin_d;
  logic [6:0]  hyst_q, hyst_d;
  logic [15:0] min_q, min_d;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [9:0]       floor_q, floor_d;
  logic                    ready_q, ready_d;
  logic                    open_q, open_d;
  logic [31:0]             start_q, start_d;
  logic signed [11:0]      peak_q, peak_d;
  logic signed [11:0]      best_q, best_d;
  logic [15:0]             acc_q, acc_d;
  logic [15:0]             rej_q, rej_d;
  logic [31:0]             air_q, air_d;
  logic [1:0]              closed_q, closed_d;
  logic [31:0]             dur_q, dur_d;

  logic signed [9:0] rssi_h_q;
  logic [31:0]       time_h_q;

  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic              neg_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [CNT_W:0]    rem_shift;
  logic              rem_ge;
  logic [9:0]        q_mag;
  logic signed [9:0] div_floor;
  logic [SUM_W-1:0]  sum_abs;

  logic [1:0]         exec_act;
  logic signed [9:0]  v;
  logic [31:0]        now;
  logic signed [9:0]  floor_eff;
  logic signed [11:0] v_ext;
  logic signed [11:0] th_on;
  logic signed [11:0] th_off;
  logic signed [11:0] peak_new;
  logic [31:0]        dur;
  logic [32:0]        air_sum;

  always_comb begin
    margin_d = margin_q;
    hyst_d   = hyst_q;
    min_d    = min_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MARGIN:     margin_d = cfg_wdata_i[6:0];
        REG_HYSTERESIS: hyst_d   = cfg_wdata_i[6:0];
        REG_MIN_EVENT:  min_d    = cfg_wdata_i;
        default:        margin_d = margin_q;
      endcase
    end
  end

  assign sts_o.need_div = (action_i == ACT_DETECT) && !ready_q;
  assign sts_o.div_busy = (cnt_q != '0);
  assign sts_o.div_done = (cnt_q == '0);

  assign sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, dsr_q};
  assign q_mag     = dvd_q[9:0];
  assign div_floor = neg_q ? $signed(-q_mag) : $signed(q_mag);

  assign exec_act  = cmd_i.use_held ? ACT_DETECT : action_i;
  assign v         = cmd_i.use_held ? rssi_h_q : rssi_i;
  assign now       = cmd_i.use_held ? time_h_q : time_ms_i;
  assign floor_eff = ready_q ? floor_q : div_floor;
  assign v_ext     = {{2{v[9]}}, v};
  assign th_on     = {{2{floor_eff[9]}}, floor_eff} + $signed({5'b0, margin_q});
  assign th_off    = th_on - $signed({5'b0, hyst_q});
  assign peak_new  = (v_ext > peak_q) ? v_ext : peak_q;
  assign dur       = now - start_q;
  assign air_sum   = {1'b0, air_q} + {1'b0, dur};

  always_comb begin
    sum_d    = sum_q;
    count_d  = count_q;
    floor_d  = floor_q;
    ready_d  = ready_q;
    open_d   = open_q;
    start_d  = start_q;
    peak_d   = peak_q;
    best_d   = best_q;
    acc_d    = acc_q;
    rej_d    = rej_q;
    air_d    = air_q;
    closed_d = closed_q;
    dur_d    = dur_q;
    if (cmd_i.exec) begin
      closed_d = CLOSE_NONE;
      dur_d    = '0;
      case (exec_act)
        ACT_CLEAR: begin
          sum_d   = '0;
          count_d = '0;
          floor_d = '0;
          ready_d = 1'b0;
          open_d  = 1'b0;
          start_d = '0;
          peak_d  = PEAK_NONE;
          best_d  = PEAK_NONE;
          acc_d   = '0;
          rej_d   = '0;
          air_d   = '0;
        end
        ACT_NOISE: begin
          if (count_q < CNT_W'(NOISE_SAMPLES_MAX)) begin
            sum_d   = sum_q + SUM_W'(v);
            count_d = count_q + 1'b1;
          end
        end
        ACT_DETECT: begin
          floor_d = floor_eff;
          ready_d = 1'b1;
          if (!open_q) begin
            if (v_ext > th_on) begin
              open_d  = 1'b1;
              start_d = now;
              peak_d  = v_ext;
            end
          end else begin
            peak_d = peak_new;
            if (v_ext < th_off) begin
              open_d = 1'b0;
              dur_d  = dur;
              peak_d = PEAK_NONE;
              if (dur < {16'b0, min_q}) begin
                closed_d = CLOSE_SHORT;
                if (rej_q != 16'hFFFF) rej_d = rej_q + 16'd1;
              end else begin
                closed_d = CLOSE_ACCEPT;
                if (acc_q != 16'hFFFF) acc_d = acc_q + 16'd1;
                air_d = air_sum[32] ? 32'hFFFF_FFFF : air_sum[31:0];
                if (peak_new > best_q) best_d = peak_new;
              end
            end
          end
        end
        default: begin
          closed_d = CLOSE_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
      hyst_q   <= HYSTERESIS_RESET;
      min_q    <= MIN_EVENT_RESET;
      sum_q    <= '0;
      count_q  <= '0;
      floor_q  <= '0;
      ready_q  <= 1'b0;
      open_q   <= 1'b0;
      start_q  <= '0;
      peak_q   <= PEAK_NONE;
      best_q   <= PEAK_NONE;
      acc_q    <= '0;
      rej_q    <= '0;
      air_q    <= '0;
      closed_q <= CLOSE_NONE;
      dur_q    <= '0;
      cnt_q    <= '0;
    end else begin
      margin_q <= margin_d;
      hyst_q   <= hyst_d;
      min_q    <= min_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      floor_q  <= floor_d;
      ready_q  <= ready_d;
      open_q   <= open_d;
      start_q  <= start_d;
      peak_q   <= peak_d;
      best_q   <= best_d;
      acc_q    <= acc_d;
      rej_q    <= rej_d;
      air_q    <= air_d;
      closed_q <= closed_d;
      dur_q    <= dur_d;
      if (cmd_i.div_start) begin
        cnt_q <= DCNT_W'(SUM_W);
      end else if (sts_o.div_busy) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rssi_h_q <= rssi_i;
      time_h_q <= time_ms_i;
    end
    if (cmd_i.div_start) begin
      dvd_q <= sum_abs;
      rem_q <= '0;
      dsr_q <= (count_q == '0) ? CNT_W'(1) : count_q;
      neg_q <= sum_q[SUM_W-1];
    end else if (sts_o.div_busy) begin
      rem_q <= rem_ge ? CNT_W'(rem_shift - {1'b0, dsr_q}) : rem_shift[CNT_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], rem_ge};
    end
  end

  assign in_event_o          = open_q;
  assign event_closed_o      = closed_q;
  assign event_duration_ms_o = dur_q;
  assign event_count_o       = acc_q;
  assign short_count_o       = rej_q;
  assign airtime_ms_o        = air_q;
  assign best_peak_o         = best_q;
  assign noise_floor_o       = floor_q;

endmodule

// ===== hdl/rssi_energy_event_detector_unit.sv =====
// RSSI energy event detector: top level joining controller and datapath.
//
// Input requests carry an action (clear, noise, detect), an RSSI sample in
// half-dB and a millisecond timestamp; each accepted request yields exactly
// one result on the output channel. Both channels use valid/ready.
// A result that needs no division is registered and appears in the cycle
// after its request is accepted. A new request is taken every cycle while
// no division runs and the output register is empty or being taken, so
// the sustained rate is one request per cycle. The first detect request of
// a run computes the noise floor with a bit-serial restoring divider, one
// quotient bit per cycle, on a dividend SUM_W bits wide, where SUM_W =
// 10 + clog2(NOISE_SAMPLES_MAX + 1) (21 at the default of 1024).
// in_ready_o is low while it runs. If the receiver stalls, the result
// register holds its value and in_ready_o drops until the result is taken.
// Configuration writes through cfg_we_i are registered; write them only
// while the block is idle. Reset restores the register defaults and clears
// all run state; no request is needed after reset.
module rssi_energy_event_detector_unit #(
  parameter int NOISE_SAMPLES_MAX = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [9:0]  rssi_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               in_event_o,
  output logic [1:0]         event_closed_o,
  output logic [31:0]        event_duration_ms_o,
  output logic [15:0]        event_count_o,
  output logic [15:0]        short_count_o,
  output logic [31:0]        airtime_ms_o,
  output logic signed [11:0] best_peak_o,
  output logic signed [9:0]  noise_floor_o
);
  import reed_pkg::*;

  reed_cmd_t cmd;
  reed_sts_t sts;

  reed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  reed_dp #(
    .NOISE_SAMPLES_MAX (NOISE_SAMPLES_MAX)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .action_i            (action_i),
    .rssi_i              (rssi_i),
    .time_ms_i           (time_ms_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_event_o          (in_event_o),
    .event_closed_o      (event_closed_o),
    .event_duration_ms_o (event_duration_ms_o),
    .event_count_o       (event_count_o),
    .short_count_o       (short_count_o),
    .airtime_ms_o        (airtime_ms_o),
    .best_peak_o         (best_peak_o),
    .noise_floor_o       (noise_floor_o)
  );

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !in_ready_o)
    else $error("request accepted while divider busy");

  a_closed_not_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_closed_o != CLOSE_NONE) |-> !in_event_o)
    else $error("event reported closed while still open");

  a_floor_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.exec |=> $stable(noise_floor_o))
    else $error("noise floor changed without a request");

endmodule
